[design/assert_macros.svh]
// Assertion macros shared by the rk5 step engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define RK5_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rk5 assertion failed");

// Condition in one cycle implies a consequence in the next.
`define RK5_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("rk5 assertion failed");

`endif

[design/rk5_pkg.sv]
// Types, constants, coefficient table and saturating helpers of the rk5 step engine.
package rk5_pkg;

    localparam int FRAC_BITS    = 32;
    localparam int WORD_BITS    = 48;
    localparam int STAGES       = 7;
    localparam int FIELD_BITS   = 48;
    localparam int STEP_BITS    = 47;
    localparam int SUBS         = 3;
    localparam int CFG_REGS     = 4;
    localparam int CFG_IDX_BITS = $clog2(CFG_REGS);
    localparam int J_BITS       = $clog2(STAGES);
    localparam int SLOPES       = STAGES * SUBS;
    localparam int ADDR_BITS    = $clog2(SLOPES);
    localparam int HALF_BITS    = (WORD_BITS + 1) / 2;

    typedef logic signed [WORD_BITS-1:0]  t_word;
    typedef logic signed [FIELD_BITS-1:0] t_field;

    localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
    localparam t_word WORD_MAX = t_word'(WMAX64);
    localparam t_word WORD_MIN = t_word'(WMIN64);

    typedef struct packed {
        t_word val;
        logic  clip;
    } t_sat;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word prod;
        logic  clip;
    } t_mul_res;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_TIME = 2'd0,
        CFG_INIT_Y0    = 2'd1,
        CFG_INIT_Y1    = 2'd2,
        CFG_INIT_Y2    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_N0, OP_N1, OP_K0, OP_K1, OP_K2, OP_HB, OP_Y
    } t_op;

    function automatic t_sat sadd(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
        r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_sat sneg(input t_word a);
        t_sat r;
        r.clip = (a == WORD_MIN);
        r.val  = r.clip ? WORD_MAX : -a;
        return r;
    endfunction

    function automatic t_sat load_field(input t_field v);
        logic signed [63:0] x;
        t_sat r;
        x = 64'(v);
        r.clip = (x > WMAX64) || (x < WMIN64);
        r.val  = (x > WMAX64) ? WORD_MAX : ((x < WMIN64) ? WORD_MIN : t_word'(x));
        return r;
    endfunction

    function automatic t_word coef_sat(input logic neg, input logic [127:0] mag);
        logic [127:0] lim;
        logic [127:0] m;
        lim = 128'(WMAX64) + (neg ? 128'd1 : 128'd0);
        m   = (mag > lim) ? lim : mag;
        return neg ? -t_word'(m) : t_word'(m);
    endfunction

    // Dormand-Prince matrix, rounded half away from zero; last row is b.
    localparam t_word COEF [STAGES][STAGES] = '{
        '{'0, '0, '0, '0, '0, '0, '0},
        '{coef_sat(1'b0, ((128'd1 << FRAC_BITS) + 128'd2) / 128'd5),
          '0, '0, '0, '0, '0, '0},
        '{coef_sat(1'b0, ((128'd3 << FRAC_BITS) + 128'd20) / 128'd40),
          coef_sat(1'b0, ((128'd9 << FRAC_BITS) + 128'd20) / 128'd40),
          '0, '0, '0, '0, '0},
        '{coef_sat(1'b0, ((128'd44 << FRAC_BITS) + 128'd22) / 128'd45),
          coef_sat(1'b1, ((128'd56 << FRAC_BITS) + 128'd7) / 128'd15),
          coef_sat(1'b0, ((128'd32 << FRAC_BITS) + 128'd4) / 128'd9),
          '0, '0, '0, '0},
        '{coef_sat(1'b0, ((128'd19372 << FRAC_BITS) + 128'd3280) / 128'd6561),
          coef_sat(1'b1, ((128'd25360 << FRAC_BITS) + 128'd1093) / 128'd2187),
          coef_sat(1'b0, ((128'd64448 << FRAC_BITS) + 128'd3280) / 128'd6561),
          coef_sat(1'b1, ((128'd212 << FRAC_BITS) + 128'd364) / 128'd729),
          '0, '0, '0},
        '{coef_sat(1'b0, ((128'd9017 << FRAC_BITS) + 128'd1584) / 128'd3168),
          coef_sat(1'b1, ((128'd355 << FRAC_BITS) + 128'd16) / 128'd33),
          coef_sat(1'b0, ((128'd46732 << FRAC_BITS) + 128'd2623) / 128'd5247),
          coef_sat(1'b0, ((128'd49 << FRAC_BITS) + 128'd88) / 128'd176),
          coef_sat(1'b1, ((128'd5103 << FRAC_BITS) + 128'd9328) / 128'd18656),
          '0, '0},
        '{coef_sat(1'b0, ((128'd35 << FRAC_BITS) + 128'd192) / 128'd384),
          '0,
          coef_sat(1'b0, ((128'd500 << FRAC_BITS) + 128'd556) / 128'd1113),
          coef_sat(1'b0, ((128'd125 << FRAC_BITS) + 128'd96) / 128'd192),
          coef_sat(1'b1, ((128'd2187 << FRAC_BITS) + 128'd3392) / 128'd6784),
          coef_sat(1'b0, ((128'd11 << FRAC_BITS) + 128'd42) / 128'd84),
          '0}
    };

endpackage

[design/rk5_in_if.sv]
// Input channel of the rk5 step engine: restart flag and step size.
interface rk5_in_if;
    import rk5_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 restart;
    logic [STEP_BITS-1:0] step_size;
    modport source (output valid, restart, step_size, input ready);
    modport sink   (input valid, restart, step_size, output ready);
endinterface

[design/rk5_out_if.sv]
// Result channel of the rk5 step engine: time, state and clip flag.
interface rk5_out_if;
    import rk5_pkg::*;
    logic   valid;
    logic   ready;
    t_field time_now;
    t_field out_y_zero;
    t_field out_y_one;
    t_field out_y_two;
    logic   saturated;
    modport source (output valid, time_now, out_y_zero, out_y_one, out_y_two, saturated,
                    input ready);
    modport sink   (input valid, time_now, out_y_zero, out_y_one, out_y_two, saturated,
                    output ready);
endinterface

[design/rk5_mul.sv]
// Shared fixed-point multiplier: half-word partial products, rounding and saturation.
`include "assert_macros.svh"
module rk5_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rk5_pkg::t_mul_req i_req,
    output rk5_pkg::t_mul_res o_res
);
    import rk5_pkg::*;

    localparam int HW = 2 * HALF_BITS;
    localparam int AW = 4 * HALF_BITS;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_ACC  = 4'b0010,
        M_FIN  = 4'b0100,
        M_DONE = 4'b1000
    } t_mstate;

    t_mstate         r_mst, n_mst;
    logic [1:0]      r_cnt;
    logic [HW-1:0]   r_ua, r_ub;
    logic            r_neg;
    logic [AW-1:0]   r_acc;
    t_word           r_prod;
    logic            r_clip;

    logic [HALF_BITS-1:0] w_ap, w_bp;
    logic [HW-1:0]        w_pp;
    logic [AW-1:0]        w_pp_sh, w_rnd, w_mag, w_lim;
    logic                 w_clip;
    logic [AW-1:0]        w_m;

    function automatic logic [HW-1:0] mag_of(input t_word v);
        return v[WORD_BITS-1] ? HW'(-{1'b0, v}) : HW'({1'b0, v});
    endfunction

    always_comb begin
        w_ap    = r_cnt[0] ? r_ua[HW-1:HALF_BITS] : r_ua[HALF_BITS-1:0];
        w_bp    = r_cnt[1] ? r_ub[HW-1:HALF_BITS] : r_ub[HALF_BITS-1:0];
        w_pp    = w_ap * w_bp;
        w_pp_sh = AW'(w_pp) << (HALF_BITS * (int'(r_cnt[0]) + int'(r_cnt[1])));
        w_rnd   = r_acc + (AW'(1) << (FRAC_BITS - 1));
        w_mag   = w_rnd >> FRAC_BITS;
        w_lim   = (AW'(1) << (WORD_BITS - 1)) - (r_neg ? AW'(0) : AW'(1));
        w_clip  = (w_mag > w_lim);
        w_m     = w_clip ? w_lim : w_mag;
    end

    always_comb begin
        n_mst = r_mst;
        unique case (r_mst)
            M_IDLE: if (i_req.start) n_mst = M_ACC;
            M_ACC:  if (r_cnt == 2'd3) n_mst = M_FIN;
            M_FIN:  n_mst = M_DONE;
            M_DONE: n_mst = M_IDLE;
            default: n_mst = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mst <= M_IDLE;
        end else begin
            r_mst <= n_mst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mst == M_IDLE && i_req.start) begin
            r_ua  <= mag_of(i_req.a);
            r_ub  <= mag_of(i_req.b);
            r_neg <= i_req.a[WORD_BITS-1] ^ i_req.b[WORD_BITS-1];
            r_acc <= '0;
            r_cnt <= 2'd0;
        end else if (r_mst == M_ACC) begin
            r_acc <= r_acc + w_pp_sh;
            r_cnt <= r_cnt + 2'd1;
        end
        if (r_mst == M_FIN) begin
            r_prod <= r_neg ? -t_word'(w_m) : t_word'(w_m);
            r_clip <= w_clip;
        end
    end

    assign o_res.done = (r_mst == M_DONE);
    assign o_res.prod = r_prod;
    assign o_res.clip = r_clip;

    `RK5_ASSERT(a_start_when_idle, i_req.start |-> (r_mst == M_IDLE))

endmodule

[design/rk5_ode_step_engine.sv]
// Top level of the rk5 step engine: sequencer, state, slopes and configuration.
//
//  channel   dir  handshake       payload
//  i_item    in   valid/ready     restart, step_size
//  o_result  out  valid/ready     time_now, out_y_zero/one/two, saturated
//  i_cfg_*   in   write enable    i_cfg_idx, i_cfg_data (48 bit)
//
// A step item issues 91 multiplies in turn to the one shared multiplier, each one
// going through issue, four half-word partial products, round and write back.
// A restart item goes straight from accept to showing its result.
// Reset clears the state vector, time and registers; slopes are written before use.
// One item at a time: i_item.ready is low from accept until the result is taken,
// and a stalled result simply holds.
`include "assert_macros.svh"
module rk5_ode_step_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rk5_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [rk5_pkg::FIELD_BITS-1:0]      i_cfg_data,
    rk5_in_if.sink                              i_item,
    rk5_out_if.source                           o_result
);
    import rk5_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [J_BITS-1:0]   r_j, n_j, r_l, n_l;
    logic [1:0]          r_r, n_r;
    t_word               r_h, n_h, r_hb, n_hb;
    t_word               r_n0, n_n0, r_n1, n_n1, r_k0, n_k0, r_k1, n_k1;
    t_word               r_y [SUBS];
    t_word               n_y [SUBS];
    t_word               r_time, n_time;
    logic                r_clip, n_clip;
    t_field              r_cfg [CFG_REGS];
    t_word               r_slope [SLOPES];

    t_mul_req            w_req;
    t_mul_res            w_mres;
    t_word               w_p, w_slope_rd;
    logic [ADDR_BITS-1:0] w_rd_addr, w_wr_addr, w_base_l, w_base_j;
    logic                w_swe;
    t_word               w_swd;
    t_sat                w_add_n0, w_add_n1, w_add_k0, w_neg_y0, w_neg_p, w_add_k1;
    t_sat                w_add_y, w_add_t;
    t_sat                w_ld [CFG_REGS];
    logic [63:0]         w_step64;
    logic                w_acc_in;

    rk5_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_mres)
    );

    assign w_p      = w_mres.prod;
    assign w_acc_in = i_item.valid && i_item.ready;
    assign w_step64 = 64'(i_item.step_size);

    // saturating adders seen by the write-back step
    assign w_add_n0 = sadd(r_n0, w_p);
    assign w_add_n1 = sadd(r_n1, w_p);
    assign w_add_k0 = sadd(r_y[1], w_p);
    assign w_neg_y0 = sneg(r_y[0]);
    assign w_neg_p  = sneg(w_p);
    assign w_add_k1 = sadd(w_neg_y0.val, w_neg_p.val);
    assign w_add_y  = sadd(r_y[r_r], w_p);
    assign w_add_t  = sadd(r_time, r_h);

    for (genvar g = 0; g < CFG_REGS; g++) begin : g_ld
        assign w_ld[g] = load_field(r_cfg[g]);
    end

    assign w_base_l = ADDR_BITS'(r_l) * ADDR_BITS'(SUBS);
    assign w_base_j = ADDR_BITS'(r_j) * ADDR_BITS'(SUBS);
    assign w_slope_rd = r_slope[w_rd_addr];

    // operand select for the shared multiplier
    always_comb begin
        w_rd_addr = w_base_j;
        w_req.a   = r_h;
        w_req.b   = r_n1;
        unique case (r_op)
            OP_N0: begin
                w_rd_addr = w_base_l;
                w_req.a   = COEF[r_j][r_l];
                w_req.b   = w_slope_rd;
            end
            OP_N1: begin
                w_rd_addr = w_base_l + ADDR_BITS'(1);
                w_req.a   = COEF[r_j][r_l];
                w_req.b   = w_slope_rd;
            end
            OP_K0: begin
                w_req.a = r_h;
                w_req.b = r_n1;
            end
            OP_K1: begin
                w_req.a = r_h;
                w_req.b = r_n0;
            end
            OP_K2: begin
                w_req.a = r_k0;
                w_req.b = r_k1;
            end
            OP_HB: begin
                w_req.a = r_h;
                w_req.b = COEF[STAGES-1][r_j];
            end
            OP_Y: begin
                w_rd_addr = w_base_j + ADDR_BITS'(r_r);
                w_req.a   = r_hb;
                w_req.b   = w_slope_rd;
            end
            default: begin
                w_req.a = r_h;
                w_req.b = r_n1;
            end
        endcase
        w_req.start = (r_state == S_RUN);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_j     = r_j;
        n_l     = r_l;
        n_r     = r_r;
        n_h     = r_h;
        n_hb    = r_hb;
        n_n0    = r_n0;
        n_n1    = r_n1;
        n_k0    = r_k0;
        n_k1    = r_k1;
        n_y     = r_y;
        n_time  = r_time;
        n_clip  = r_clip;
        w_swe     = 1'b0;
        w_wr_addr = w_base_j;
        w_swd     = w_p;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    if (i_item.restart) begin
                        n_time  = w_ld[CFG_START_TIME].val;
                        n_y[0]  = w_ld[CFG_INIT_Y0].val;
                        n_y[1]  = w_ld[CFG_INIT_Y1].val;
                        n_y[2]  = w_ld[CFG_INIT_Y2].val;
                        n_clip  = w_ld[CFG_START_TIME].clip | w_ld[CFG_INIT_Y0].clip |
                                  w_ld[CFG_INIT_Y1].clip | w_ld[CFG_INIT_Y2].clip;
                        n_state = S_OUT;
                    end else begin
                        n_clip  = (w_step64 > 64'(WMAX64));
                        n_h     = n_clip ? WORD_MAX : t_word'(w_step64);
                        n_j     = '0;
                        n_l     = '0;
                        n_n0    = '0;
                        n_n1    = '0;
                        n_op    = OP_K0;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: n_state = S_WAIT;
            S_WAIT: begin
                if (w_mres.done) begin
                    n_state = S_RUN;
                    n_clip  = r_clip | w_mres.clip;
                    unique case (r_op)
                        OP_N0: begin
                            n_n0   = w_add_n0.val;
                            n_clip = n_clip | w_add_n0.clip;
                            n_op   = OP_N1;
                        end
                        OP_N1: begin
                            n_n1   = w_add_n1.val;
                            n_clip = n_clip | w_add_n1.clip;
                            if (r_l + J_BITS'(1) != r_j) begin
                                n_l  = r_l + J_BITS'(1);
                                n_op = OP_N0;
                            end else begin
                                n_op = OP_K0;
                            end
                        end
                        OP_K0: begin
                            n_k0      = w_add_k0.val;
                            n_clip    = n_clip | w_add_k0.clip;
                            w_swe     = 1'b1;
                            w_swd     = w_add_k0.val;
                            n_op      = OP_K1;
                        end
                        OP_K1: begin
                            n_k1      = w_add_k1.val;
                            n_clip    = n_clip | w_neg_y0.clip | w_neg_p.clip | w_add_k1.clip;
                            w_swe     = 1'b1;
                            w_wr_addr = w_base_j + ADDR_BITS'(1);
                            w_swd     = w_add_k1.val;
                            n_op      = OP_K2;
                        end
                        OP_K2: begin
                            n_clip    = n_clip | w_neg_p.clip;
                            w_swe     = 1'b1;
                            w_wr_addr = w_base_j + ADDR_BITS'(2);
                            w_swd     = w_neg_p.val;
                            if (r_j != J_BITS'(STAGES - 1)) begin
                                n_j  = r_j + J_BITS'(1);
                                n_l  = '0;
                                n_n0 = '0;
                                n_n1 = '0;
                                n_op = OP_N0;
                            end else begin
                                n_j  = '0;
                                n_op = OP_HB;
                            end
                        end
                        OP_HB: begin
                            n_hb = w_p;
                            n_r  = 2'd0;
                            n_op = OP_Y;
                        end
                        OP_Y: begin
                            n_y[r_r] = w_add_y.val;
                            n_clip   = n_clip | w_add_y.clip;
                            if (r_r != 2'd2) begin
                                n_r = r_r + 2'd1;
                            end else if (r_j != J_BITS'(STAGES - 1)) begin
                                n_j  = r_j + J_BITS'(1);
                                n_op = OP_HB;
                            end else begin
                                // last update of the step: advance time, show result
                                n_time  = w_add_t.val;
                                n_clip  = n_clip | w_add_y.clip | w_add_t.clip;
                                n_state = S_OUT;
                            end
                        end
                        default: n_op = OP_K0;
                    endcase
                end
            end
            S_OUT: if (o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_K0;
            r_time  <= '0;
            r_y     <= '{default: '0};
            r_cfg   <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_time  <= n_time;
            r_y     <= n_y;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_TIME: r_cfg[CFG_START_TIME] <= i_cfg_data;
                    CFG_INIT_Y0:    r_cfg[CFG_INIT_Y0]    <= i_cfg_data;
                    CFG_INIT_Y1:    r_cfg[CFG_INIT_Y1]    <= i_cfg_data;
                    CFG_INIT_Y2:    r_cfg[CFG_INIT_Y2]    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_l    <= n_l;
        r_r    <= n_r;
        r_h    <= n_h;
        r_hb   <= n_hb;
        r_n0   <= n_n0;
        r_n1   <= n_n1;
        r_k0   <= n_k0;
        r_k1   <= n_k1;
        r_clip <= n_clip;
        if (w_swe) r_slope[w_wr_addr] <= w_swd;
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_result.valid      = (r_state == S_OUT);
    assign o_result.time_now   = FIELD_BITS'(r_time);
    assign o_result.out_y_zero = FIELD_BITS'(r_y[0]);
    assign o_result.out_y_one  = FIELD_BITS'(r_y[1]);
    assign o_result.out_y_two  = FIELD_BITS'(r_y[2]);
    assign o_result.saturated  = r_clip;

    `RK5_ASSERT_NEXT(a_busy_after_accept, i_item.valid && i_item.ready, !i_item.ready)
    `RK5_ASSERT(a_done_only_waiting, w_mres.done |-> (r_state == S_WAIT))
    `RK5_ASSERT(a_component_in_range, (r_op == OP_Y) |-> (r_r != 2'd3))

endmodule

[tb/rk5_ode_step_engine_tb.sv]
// Self-checking testbench of the rk5 step engine: random items and stalls against a predictor.
module rk5_ode_step_engine_tb;
    import rk5_pkg::*;

    // One input item and one predicted result.
    typedef struct {
        logic                 restart;
        logic [STEP_BITS-1:0] step;
    } t_step_item;

    typedef struct {
        t_field tm;
        t_field y0;
        t_field y1;
        t_field y2;
        logic   sat;
    } t_ode_snap;

    localparam int WATCHDOG_CYCLES = 40000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [FIELD_BITS-1:0]   i_cfg_data;

    rk5_in_if  item_ch ();
    rk5_out_if res_ch ();

    rk5_ode_step_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    // Clock: period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: our own copy of registers, state vector, time and slopes
    t_word      reg_copy [CFG_REGS];
    t_word      y_vec    [SUBS];
    t_word      t_acc;
    t_word      slope    [STAGES][SUBS];
    t_word      dp_coef  [STAGES][STAGES];
    logic       clipped;

    t_step_item step_q [$];     // items waiting for the driver
    t_ode_snap  snap_q [$];     // predicted results, oldest first
    int         items_queued;
    int         results_seen;
    int         mismatches;
    int         quiet_cycles;
    bit         no_idle;        // stretch with no idling on either side

    // ---------------------------------------------------------------
    // Saturating fixed-point arithmetic (Q16.32 in a 48-bit word)
    // ---------------------------------------------------------------
    function automatic t_word clamp_mag(logic [127:0] mag, logic neg);
        logic [127:0] lim;
        lim = neg ? (128'd1 << (WORD_BITS - 1)) : ((128'd1 << (WORD_BITS - 1)) - 128'd1);
        if (mag > lim) begin
            clipped = 1'b1;
            mag = lim;
        end
        return neg ? t_word'(128'd0 - mag) : t_word'(mag);
    endfunction

    function automatic t_word fx_add(t_word a, t_word b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(WORD_MAX)) begin
            clipped = 1'b1;
            return WORD_MAX;
        end
        if (s < longint'(WORD_MIN)) begin
            clipped = 1'b1;
            return WORD_MIN;
        end
        return t_word'(s);
    endfunction

    function automatic t_word fx_neg(t_word a);
        if (a == WORD_MIN) begin
            clipped = 1'b1;
            return WORD_MAX;
        end
        return -a;
    endfunction

    // Product rounded half away from zero on the magnitude, then clamped
    function automatic t_word fx_mul(t_word a, t_word b);
        longint la;
        longint lb;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        la = a;
        lb = b;
        ma = (la < 0) ? -la : la;
        mb = (lb < 0) ? -lb : lb;
        p  = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return clamp_mag(p, (la < 0) != (lb < 0));
    endfunction

    function automatic t_word dp_ratio(int num, int den);
        logic [127:0] up;
        up = (num < 0) ? -num : num;
        return clamp_mag(((up << FRAC_BITS) + den / 2) / den, num < 0);
    endfunction

    // Dormand-Prince tableau; the last row doubles as the b weights
    task automatic build_tableau();
        int num [STAGES][STAGES];
        int den [STAGES][STAGES];
        num = '{'{0, 0, 0, 0, 0, 0, 0},
                '{1, 0, 0, 0, 0, 0, 0},
                '{3, 9, 0, 0, 0, 0, 0},
                '{44, -56, 32, 0, 0, 0, 0},
                '{19372, -25360, 64448, -212, 0, 0, 0},
                '{9017, -355, 46732, 49, -5103, 0, 0},
                '{35, 0, 500, 125, -2187, 11, 0}};
        den = '{'{1, 1, 1, 1, 1, 1, 1},
                '{5, 1, 1, 1, 1, 1, 1},
                '{40, 40, 1, 1, 1, 1, 1},
                '{45, 15, 9, 1, 1, 1, 1},
                '{6561, 2187, 6561, 729, 1, 1, 1},
                '{3168, 33, 5247, 176, 18656, 1, 1},
                '{384, 1, 1113, 192, 6784, 84, 1}};
        for (int j = 0; j < STAGES; j++)
            for (int l = 0; l < STAGES; l++)
                dp_coef[j][l] = dp_ratio(num[j][l], den[j][l]);
    endtask

    // Apply one accepted item to the predicted state; returns the expected result
    function automatic t_ode_snap advance_ode(t_step_item it);
        t_ode_snap s;
        t_word h;
        t_word n0;
        t_word n1;
        t_word k0;
        t_word k1;
        t_word hb;
        clipped = 1'b0;
        if (it.restart) begin
            // registers are as wide as the word, so loading never clamps
            t_acc = reg_copy[CFG_START_TIME];
            y_vec[0] = reg_copy[CFG_INIT_Y0];
            y_vec[1] = reg_copy[CFG_INIT_Y1];
            y_vec[2] = reg_copy[CFG_INIT_Y2];
        end else begin
            h = clamp_mag(128'(it.step), 1'b0);
            for (int j = 0; j < STAGES; j++) begin
                n0 = '0;
                n1 = '0;
                for (int l = 0; l < j; l++) begin
                    n0 = fx_add(n0, fx_mul(dp_coef[j][l], slope[l][0]));
                    n1 = fx_add(n1, fx_mul(dp_coef[j][l], slope[l][1]));
                end
                k0 = fx_add(y_vec[1], fx_mul(h, n1));
                k1 = fx_add(fx_neg(y_vec[0]), fx_neg(fx_mul(h, n0)));
                slope[j][0] = k0;
                slope[j][1] = k1;
                slope[j][2] = fx_neg(fx_mul(k0, k1));
            end
            for (int j = 0; j < STAGES; j++) begin
                hb = fx_mul(h, dp_coef[STAGES-1][j]);
                for (int r = 0; r < SUBS; r++)
                    y_vec[r] = fx_add(y_vec[r], fx_mul(hb, slope[j][r]));
            end
            t_acc = fx_add(t_acc, h);
        end
        s.tm  = t_acc;
        s.y0  = y_vec[0];
        s.y1  = y_vec[1];
        s.y2  = y_vec[2];
        s.sat = clipped;
        return s;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents items from step_q, random gaps between them
    // ---------------------------------------------------------------
    int drv_gap;

    always @(posedge i_clk) begin
        t_step_item it;
        if (!i_rst_n) begin
            item_ch.valid     <= 1'b0;
            item_ch.restart   <= 1'b0;
            item_ch.step_size <= '0;
            drv_gap = 0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                snap_q.push_back(advance_ode('{item_ch.restart, item_ch.step_size}));
            if (!(item_ch.valid && !item_ch.ready)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    item_ch.valid <= 1'b0;
                end else if (step_q.size() > 0) begin
                    it = step_q.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.restart   <= it.restart;
                    item_ch.step_size <= it.step;
                    drv_gap = gap_len();
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, compares each result with the oldest prediction
    // ---------------------------------------------------------------
    int mon_gap;

    always @(posedge i_clk) begin
        t_ode_snap e;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mon_gap = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (snap_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing expected: t=%h y=%h %h %h sat=%b",
                                 res_ch.time_now, res_ch.out_y_zero, res_ch.out_y_one,
                                 res_ch.out_y_two, res_ch.saturated);
                end else begin
                    e = snap_q.pop_front();
                    if (res_ch.time_now !== e.tm || res_ch.out_y_zero !== e.y0 ||
                        res_ch.out_y_one !== e.y1 || res_ch.out_y_two !== e.y2 ||
                        res_ch.saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch #%0d: expected t=%h y=%h %h %h sat=%b",
                                     results_seen, e.tm, e.y0, e.y1, e.y2, e.sat);
                            $display("               got      t=%h y=%h %h %h sat=%b",
                                     res_ch.time_now, res_ch.out_y_zero, res_ch.out_y_one,
                                     res_ch.out_y_two, res_ch.saturated);
                        end
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid && res_ch.ready)
                    mon_gap = gap_len();
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("rk5_ode_step_engine_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_item(logic rs, logic [STEP_BITS-1:0] h);
        step_q.push_back('{rs, h});
        items_queued++;
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain();
        while (results_seen < items_queued)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges; only called when idle
    task automatic load_regs(t_word tm, t_word y0, t_word y1, t_word y2);
        t_word v [CFG_REGS];
        v = '{tm, y0, y1, y2};
        for (int i = 0; i < CFG_REGS; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= v[i];
            reg_copy[i] = v[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_word rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return t_word'((longint'($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 15);
        if (r < 8) return t_word'({$urandom, $urandom});
        if (r == 8) return WORD_MAX;
        return WORD_MIN;
    endfunction

    function automatic logic [STEP_BITS-1:0] rand_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 7) return STEP_BITS'({$urandom, $urandom});
        if (r < 10) return STEP_BITS'({$urandom_range(1, 1 << 14), $urandom});
        return STEP_BITS'($urandom_range(0, 1 << 30));
    endfunction

    localparam logic [STEP_BITS-1:0] ONE_STEP = STEP_BITS'(64'd1 << FRAC_BITS);
    localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'(1);

    initial begin
        int n;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        items_queued  = 0;
        results_seen  = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        for (int i = 0; i < CFG_REGS; i++) reg_copy[i] = '0;
        for (int i = 0; i < SUBS; i++) y_vec[i] = '0;
        t_acc = '0;
        build_tableau();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Steps before any restart run from the all-zero reset state
        queue_item(1'b0, ONE_STEP);
        queue_item(1'b0, '1);
        queue_item(1'b0, '0);
        queue_item(1'b1, '1);       // restart with reset registers, step ignored
        queue_item(1'b0, MIN_STEP);
        drain();

        // Register extremes: steps saturate almost at once
        load_regs(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        queue_item(1'b1, '0);
        queue_item(1'b0, MIN_STEP);
        queue_item(1'b0, '0);       // zero step leaves state and time alone
        queue_item(1'b0, '1);       // largest step
        queue_item(1'b1, ONE_STEP);
        queue_item(1'b0, ONE_STEP);
        drain();

        load_regs(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        queue_item(1'b1, '0);
        queue_item(1'b0, ONE_STEP >> 4);
        queue_item(1'b0, 47'h2AAA_AAAA_AAAA);
        drain();

        // Well-behaved harmonic start: y0 = 1, y1 = 0, y2 = 0.5
        load_regs('0, t_word'(64'd1 << FRAC_BITS), '0, t_word'(64'd1 << (FRAC_BITS - 1)));
        queue_item(1'b1, '0);
        for (int i = 0; i < 6; i++) queue_item(1'b0, ONE_STEP >> 3);
        queue_item(1'b0, 47'h5555_5555_5555);
        drain();

        // Random phases: usually a restart, then mostly steps of modest size
        for (int ph = 0; ph < 12; ph++) begin
            no_idle = (ph % 4 == 3);
            load_regs(rand_word(), rand_word(), rand_word(), rand_word());
            n = $urandom_range(80, 110);
            if ($urandom_range(0, 9) < 8) queue_item(1'b1, rand_step());
            for (int i = 0; i < n; i++)
                queue_item($urandom_range(0, 99) < 4, rand_step());
            drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && snap_q.size() == 0)
            $display("rk5_ode_step_engine_tb OK");
        else
            $display("rk5_ode_step_engine_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/rk5_pkg.sv
design/rk5_in_if.sv
design/rk5_out_if.sv
design/rk5_mul.sv
design/rk5_ode_step_engine.sv
tb/rk5_ode_step_engine_tb.sv
